// ===== hw/rtl/fbfla_pkg.sv =====
package fbfla_pkg;

    // Field and register widths fixed by the interface
    localparam int KIND_W    = 1;
    localparam int OFF_W     = 20;
    localparam int SIZE_W    = 13;
    localparam int CNT_W     = 9;
    localparam int IDX_OUT_W = 8;
    localparam int VER_OUT_W = 16;
    localparam int STATUS_W  = 2;
    localparam int REG_IDX_W = 1;

    // Bytes of header ahead of each block's user data
    localparam int HDR_BYTES = 8;

    // Block size saturation bounds
    localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd16;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] BLOCK_BYTES_RST = 13'd16;
    localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_ADDR  = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_RD,
        S_ALOC,
        S_FREE,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic take_in;
        logic mul;
        logic pend_empty;
        logic pend_bad;
        logic pend_notalloc;
        logic div_start;
        logic div_step;
        logic rd_free;
        logic do_alloc;
        logic do_free;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic kind_free;
        logic empty;
        logic addr_bad;
        logic div_last;
        logic rem_zero;
        logic blk_alloc;
    } t_sts;

endpackage

// ===== hw/rtl/fixed_block_free_list_allocator_unit.sv =====
// Fixed-size block pool allocator with an index-linked free list. Words are
// handled one at a time: an allocate is accepted, then steps through the
// multiply, the link store read/update and the result load, skipping the
// link store when the pool is empty. A free that passes the range check is
// resolved by the restoring divider, one quotient bit per cycle from
// (offset - header) / block size; an offset off a block boundary skips the
// link store update, and one below the header or past the last block skips
// the divider. The input is ready again the cycle after the result is loaded
// into the output register, so a pending result does not block the next word.
// No clearing pass is needed after reset: a fill mark makes never-touched
// link entries read as index + 1 and their allocated flag as clear.
// Configuration is to be written only while the block is idle, which the
// block itself does not enforce; the config port is always ready.
module fixed_block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS   = 256,
    parameter int VERSION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fbfla_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbfla_pkg::SIZE_W-1:0]         i_cfg_data,
    // request words
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [fbfla_pkg::KIND_W-1:0]         i_kind,
    input  logic [fbfla_pkg::OFF_W-1:0]          i_user_offset,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [fbfla_pkg::STATUS_W-1:0]       o_status,
    output logic [fbfla_pkg::IDX_OUT_W-1:0]      o_block_index,
    output logic [fbfla_pkg::OFF_W-1:0]          o_data_offset,
    output logic [fbfla_pkg::CNT_W-1:0]          o_avail_blocks,
    output logic [fbfla_pkg::VER_OUT_W-1:0]      o_head_version
);
    import fbfla_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fbfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fbfla_dpath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .VERSION_BITS (VERSION_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_user_offset  (i_user_offset),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_block_index  (o_block_index),
        .o_data_offset  (o_data_offset),
        .o_avail_blocks (o_avail_blocks),
        .o_head_version (o_head_version)
    );

endmodule

// ===== hw/rtl/fbfla_ram.sv =====
module fbfla_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]                          i_wr_data,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]                          o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/fbfla_dpath.sv =====
module fbfla_dpath #(
    parameter int MAX_BLOCKS   = 256,
    parameter int VERSION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [fbfla_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbfla_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic [fbfla_pkg::KIND_W-1:0]         i_kind,
    input  logic [fbfla_pkg::OFF_W-1:0]          i_user_offset,
    input  fbfla_pkg::t_cmd                      i_cmd,
    output fbfla_pkg::t_sts                      o_sts,
    output logic [fbfla_pkg::STATUS_W-1:0]       o_status,
    output logic [fbfla_pkg::IDX_OUT_W-1:0]      o_block_index,
    output logic [fbfla_pkg::OFF_W-1:0]          o_data_offset,
    output logic [fbfla_pkg::CNT_W-1:0]          o_avail_blocks,
    output logic [fbfla_pkg::VER_OUT_W-1:0]      o_head_version
);
    import fbfla_pkg::*;

    // Block index, list link and product widths
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = SIZE_W + LW;
    localparam int XW = (PW > OFF_W) ? PW : OFF_W;
    localparam int RW = (SIZE_W + IW > OFF_W) ? SIZE_W + IW : OFF_W;
    localparam int SW = (IW > 1) ? $clog2(IW) : 1;
    localparam int MW = LW + 1;

    // Configuration and list state
    logic [SIZE_W-1:0]       r_blk_bytes;
    logic [CNT_W-1:0]        r_blk_count;
    logic [LW-1:0]           r_head;
    logic [LW-1:0]           r_fill;
    logic [LW-1:0]           r_used;
    logic [VERSION_BITS-1:0] r_tag;

    // Per-word working registers
    logic [KIND_W-1:0]       r_kind;
    logic [OFF_W-1:0]        r_uoff;
    logic [PW-1:0]           r_prod;
    logic [RW-1:0]           r_rem;
    logic [RW-1:0]           r_div;
    logic [IW-1:0]           r_quo;
    logic [SW-1:0]           r_step;
    t_status                 r_res_status;
    logic [IW-1:0]           r_res_idx;
    logic [OFF_W-1:0]        r_res_doff;

    // Output word
    t_status                 r_out_status;
    logic [IDX_OUT_W-1:0]    r_out_idx;
    logic [OFF_W-1:0]        r_out_doff;
    logic [CNT_W-1:0]        r_out_free;
    logic [VER_OUT_W-1:0]    r_out_ver;

    logic [SIZE_W-1:0]       size_al;
    logic [SIZE_W-1:0]       eff_size;
    logic [31:0]             cnt_sat;
    logic [LW-1:0]           eff_cnt;
    logic [LW-1:0]           mul_b;
    logic [OFF_W-1:0]        internal;
    logic                    below_hdr;
    logic                    over_end;
    logic                    div_ge;
    logic                    fresh;
    logic [LW-1:0]           link_next;
    logic [XW-1:0]           doff_calc;
    logic [LW-1:0]           free_blks;
    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [MW-1:0]           ram_wdata;
    logic [IW-1:0]           ram_raddr;
    logic [MW-1:0]           ram_rdata;

    // Effective block size: 8-aligned, saturated to 16..4096
    always_comb begin
        size_al = {r_blk_bytes[SIZE_W-1:3], 3'b000};
        if (size_al < SIZE_MIN) begin
            eff_size = SIZE_MIN;
        end else if (size_al > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = size_al;
        end
    end

    // Effective block count: saturated to 1..MAX_BLOCKS
    always_comb begin
        cnt_sat = 32'(r_blk_count);
        if (r_blk_count == '0) begin
            cnt_sat = 32'd1;
        end else if (cnt_sat > 32'(MAX_BLOCKS)) begin
            cnt_sat = 32'(MAX_BLOCKS);
        end
        eff_cnt = cnt_sat[LW-1:0];
    end

    // Address checks against the registered size * count product
    assign mul_b     = (r_kind == KIND_FREE) ? eff_cnt : r_head;
    assign internal  = r_uoff - OFF_W'(HDR_BYTES);
    assign below_hdr = r_uoff < OFF_W'(HDR_BYTES);
    assign over_end  = XW'(internal) >= XW'(r_prod);
    assign doff_calc = XW'(r_prod) + XW'(HDR_BYTES);
    assign div_ge    = r_rem >= r_div;

    // Entries at or past the fill mark were never written: link i reads i+1
    assign fresh     = r_head >= r_fill;
    assign link_next = fresh ? r_head + LW'(1) : ram_rdata[LW-1:0];

    assign free_blks = (eff_cnt > r_used) ? eff_cnt - r_used : '0;

    always_comb begin
        o_sts.kind_free = (r_kind == KIND_FREE);
        o_sts.empty     = r_head >= eff_cnt;
        o_sts.addr_bad  = below_hdr | over_end;
        o_sts.div_last  = (r_step == '0);
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.blk_alloc = (LW'(r_quo) < r_fill) & ram_rdata[LW];
    end

    // Link/flag store: {allocated, link}
    assign ram_we    = i_cmd.do_alloc | i_cmd.do_free;
    assign ram_waddr = i_cmd.do_free ? r_quo : r_head[IW-1:0];
    assign ram_wdata = i_cmd.do_free ? {1'b0, r_head} : {1'b1, link_next};
    assign ram_raddr = i_cmd.rd_free ? r_quo : r_head[IW-1:0];

    fbfla_ram #(
        .P_WIDTH (MW),
        .P_DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // Configuration and list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_bytes <= BLOCK_BYTES_RST;
            r_blk_count <= BLOCK_COUNT_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_used      <= '0;
            r_tag       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_BLOCK_BYTES: r_blk_bytes <= i_cfg_data;
                    REG_BLOCK_COUNT: r_blk_count <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.do_alloc) begin
                r_head <= link_next;
                if (fresh) begin
                    r_fill <= r_fill + LW'(1);
                end
                r_used <= r_used + LW'(1);
                r_tag  <= r_tag + VERSION_BITS'(1);
            end else if (i_cmd.do_free) begin
                r_head <= LW'(r_quo);
                if (r_used != '0) begin
                    r_used <= r_used - LW'(1);
                end
                r_tag  <= r_tag + VERSION_BITS'(1);
            end
        end
    end

    // Working registers, divider and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_kind       <= i_kind;
            r_uoff       <= i_user_offset;
            r_res_status <= ST_OK;
            r_res_idx    <= '0;
            r_res_doff   <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(eff_size) * PW'(mul_b);
        end
        // restoring divide, one quotient bit a cycle
        if (i_cmd.div_start) begin
            r_rem  <= RW'(internal);
            r_div  <= RW'(eff_size) << (IW - 1);
            r_quo  <= '0;
            r_step <= SW'(IW - 1);
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div  <= r_div >> 1;
            r_quo  <= (r_quo << 1) | IW'(div_ge);
            r_step <= r_step - SW'(1);
        end
        if (i_cmd.pend_empty) begin
            r_res_status <= ST_EMPTY;
        end else if (i_cmd.pend_bad) begin
            r_res_status <= ST_BAD_ADDR;
        end else if (i_cmd.pend_notalloc) begin
            r_res_status <= ST_NOT_ALLOC;
        end
        if (i_cmd.do_alloc) begin
            r_res_idx  <= r_head[IW-1:0];
            r_res_doff <= doff_calc[OFF_W-1:0];
        end else if (i_cmd.do_free) begin
            r_res_idx  <= r_quo;
            r_res_doff <= r_uoff;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= IDX_OUT_W'(r_res_idx);
            r_out_doff   <= r_res_doff;
            r_out_free   <= CNT_W'(free_blks);
            r_out_ver    <= r_tag[VER_OUT_W-1:0];
        end
    end

    assign o_status       = r_out_status;
    assign o_block_index  = r_out_idx;
    assign o_data_offset  = r_out_doff;
    assign o_avail_blocks = r_out_free;
    assign o_head_version = r_out_ver;

endmodule

// ===== hw/rtl/fbfla_ctrl.sv =====
module fbfla_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  fbfla_pkg::t_sts i_sts,
    output fbfla_pkg::t_cmd o_cmd
);
    import fbfla_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.kind_free) begin
                    n_state = S_CHK;
                end else if (i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ALOC;
                end
            end
            S_CHK: begin
                n_state = i_sts.addr_bad ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = i_sts.rem_zero ? S_FREE : S_DONE;
            end
            S_ALOC: begin
                n_state = S_DONE;
            end
            S_FREE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.take_in = i_in_valid;
            S_MUL: begin
                o_cmd.mul        = 1'b1;
                o_cmd.pend_empty = !i_sts.kind_free && i_sts.empty;
            end
            S_CHK: begin
                o_cmd.div_start = !i_sts.addr_bad;
                o_cmd.pend_bad  = i_sts.addr_bad;
            end
            S_DIV: o_cmd.div_step = 1'b1;
            S_RD: begin
                o_cmd.rd_free  = 1'b1;
                o_cmd.pend_bad = !i_sts.rem_zero;
            end
            S_ALOC: o_cmd.do_alloc = 1'b1;
            S_FREE: begin
                o_cmd.do_free       = i_sts.blk_alloc;
                o_cmd.pend_notalloc = !i_sts.blk_alloc;
            end
            S_DONE: o_cmd.load_out = slot_free;
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
